// File: sv/fcb_pkg.sv
// ----------------------------------------------------------------------------
// fcb_pkg: shared types for the clipped framebuffer blit unit
// Action codes, the classified command that travels from the front end to the
// back end, and the status the back end returns.
// ----------------------------------------------------------------------------
package fcb_pkg;

    typedef enum logic [1:0] {
        ACT_WR_SPRITE = 2'd0,
        ACT_WR_FRAME  = 2'd1,
        ACT_RD_FRAME  = 2'd2,
        ACT_BLIT      = 2'd3
    } action_t;

    // The sprite store is always 64 pixels wide.
    localparam int SPRITE_ROW  = 64;
    // Width used for byte address arithmetic (covers the largest store).
    localparam int WIDE_W      = 13;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    typedef struct packed {
        action_t           action;
        logic              addr_ok;
        logic [8:0]        address;
        logic [7:0]        data;
        logic [5:0]        src_x;
        logic [5:0]        src_y;
        logic signed [7:0] dest_x;
        logic signed [7:0] dest_y;
        logic              empty;
        logic [6:0]        col_first;
        logic [6:0]        col_last;
        logic [6:0]        row_first;
        logic [6:0]        row_last;
    } cmd_t;

    typedef struct packed {
        logic clearing;
        logic pop;
    } back_status_t;

endpackage

// File: sv/framebuffer_clipped_blit_unit.sv
// ----------------------------------------------------------------------------
// framebuffer_clipped_blit_unit: one-bit framebuffer with clipped sprite blit
// Holds a page-layout framebuffer and a 64-wide sprite store and copies
// rectangles from the sprite store to the screen with clipping.
// ----------------------------------------------------------------------------
// Usage: each beat on the s_ channel carries one command (write sprite byte,
// write frame byte, read frame byte, blit). Every command returns exactly one
// beat on the m_ channel; m_is_read marks a read, and m_read_byte is zero for
// all other commands. Commands complete strictly in order.
// Flow: a write goes from the idle state straight to the result state, a read
// passes through a read state first, and a blit walks the clipped rectangle,
// one on-screen destination pixel per cycle (up to 2048 for a 64 by 32 screen),
// through a framebuffer read / modify-write pipeline and a drain state; the
// single framebuffer write port sets that rate. The next command starts when
// the previous one has finished.
// A two-entry command queue keeps s_ready high while a result waits, until full;
// when the receiver stalls, the block finishes the current command and holds it.
// After reset both stores are cleared in one pass over max(frame bytes, sprite
// bytes) addresses (512 at the default size); s_ready stays low during it.
// ----------------------------------------------------------------------------
module framebuffer_clipped_blit_unit #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32,
    parameter int SPRITE_HEIGHT = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_action,
    input  logic [8:0]        s_address,
    input  logic [7:0]        s_data,
    input  logic [5:0]        s_src_x,
    input  logic [5:0]        s_src_y,
    input  logic [6:0]        s_width,
    input  logic [6:0]        s_height,
    input  logic signed [7:0] s_dest_x,
    input  logic signed [7:0] s_dest_y,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_read_byte,
    output logic              m_is_read
);

    fcb_pkg::cmd_t         q_cmd;
    logic                  q_valid;
    fcb_pkg::back_status_t status;

    fcb_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .SPRITE_HEIGHT (SPRITE_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_address (s_address),
        .s_data    (s_data),
        .s_src_x   (s_src_x),
        .s_src_y   (s_src_y),
        .s_width   (s_width),
        .s_height  (s_height),
        .s_dest_x  (s_dest_x),
        .s_dest_y  (s_dest_y),
        .status    (status),
        .q_cmd     (q_cmd),
        .q_valid   (q_valid)
    );

    fcb_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .SPRITE_HEIGHT (SPRITE_HEIGHT)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_cmd       (q_cmd),
        .q_valid     (q_valid),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_byte (m_read_byte),
        .m_is_read   (m_is_read)
    );

endmodule

// File: sv/fcb_ram.sv
// ----------------------------------------------------------------------------
// fcb_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module fcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/fcb_front.sv
// ----------------------------------------------------------------------------
// fcb_front: input stage of the blit unit
// Accepts beats, checks byte addresses against the store sizes, clips the
// blit rectangle to the screen, and queues the classified command.
// ----------------------------------------------------------------------------
module fcb_front #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32,
    parameter int SPRITE_HEIGHT = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_action,
    input  logic [8:0]           s_address,
    input  logic [7:0]           s_data,
    input  logic [5:0]           s_src_x,
    input  logic [5:0]           s_src_y,
    input  logic [6:0]           s_width,
    input  logic [6:0]           s_height,
    input  logic signed [7:0]    s_dest_x,
    input  logic signed [7:0]    s_dest_y,
    input  fcb_pkg::back_status_t status,
    output fcb_pkg::cmd_t        q_cmd,
    output logic                 q_valid
);

    localparam int FRAME_BYTES  = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
    localparam int SPRITE_BYTES = fcb_pkg::SPRITE_ROW * ((SPRITE_HEIGHT + 7) / 8);

    logic signed [10:0] dx_ext, dy_ext, neg_dx, neg_dy;
    logic signed [10:0] c0, c1, r0, r1, c_edge, r_edge, w_ext, h_ext, c1m1, r1m1;
    logic [fcb_pkg::WIDE_W-1:0] addr_wide;
    fcb_pkg::action_t act;
    fcb_pkg::cmd_t    cmd_in;

    fcb_pkg::cmd_t               q_mem_reg [fcb_pkg::QUEUE_DEPTH];
    logic [fcb_pkg::QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [fcb_pkg::QPTR_W:0]    count_reg;
    logic                        full, push;

    // Visible columns are [c0, c1) in rectangle coordinates; rows likewise.
    always_comb begin
        act    = fcb_pkg::action_t'(s_action);
        dx_ext = {{3{s_dest_x[7]}}, s_dest_x};
        dy_ext = {{3{s_dest_y[7]}}, s_dest_y};
        neg_dx = -dx_ext;
        neg_dy = -dy_ext;
        c0     = (neg_dx > 11'sd0) ? neg_dx : 11'sd0;
        r0     = (neg_dy > 11'sd0) ? neg_dy : 11'sd0;
        c_edge = $signed(11'(SCREEN_WIDTH)) - dx_ext;
        r_edge = $signed(11'(SCREEN_HEIGHT)) - dy_ext;
        w_ext  = $signed({4'b0, s_width});
        h_ext  = $signed({4'b0, s_height});
        c1     = (w_ext < c_edge) ? w_ext : c_edge;
        r1     = (h_ext < r_edge) ? h_ext : r_edge;
        c1m1   = c1 - 11'sd1;
        r1m1   = r1 - 11'sd1;

        addr_wide = {4'b0, s_address};

        cmd_in.action    = act;
        cmd_in.addr_ok   = (act == fcb_pkg::ACT_WR_SPRITE)
                         ? (addr_wide < fcb_pkg::WIDE_W'(SPRITE_BYTES))
                         : (addr_wide < fcb_pkg::WIDE_W'(FRAME_BYTES));
        cmd_in.address   = s_address;
        cmd_in.data      = s_data;
        cmd_in.src_x     = s_src_x;
        cmd_in.src_y     = s_src_y;
        cmd_in.dest_x    = s_dest_x;
        cmd_in.dest_y    = s_dest_y;
        cmd_in.empty     = (c1 <= c0) || (r1 <= r0);
        cmd_in.col_first = c0[6:0];
        cmd_in.col_last  = c1m1[6:0];
        cmd_in.row_first = r0[6:0];
        cmd_in.row_last  = r1m1[6:0];
    end

    assign full    = (count_reg == (fcb_pkg::QPTR_W + 1)'(fcb_pkg::QUEUE_DEPTH));
    assign s_ready = !full && !status.clearing;
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_cmd   = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (status.pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !status.pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && status.pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    a_pop_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        status.pop |-> q_valid)
        else $error("back end popped an empty command queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (fcb_pkg::QPTR_W + 1)'(fcb_pkg::QUEUE_DEPTH))
        else $error("command queue count overflowed");

    a_no_push_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        status.clearing |-> !push)
        else $error("beat accepted while the stores were being cleared");

endmodule

// File: sv/fcb_back.sv
// ----------------------------------------------------------------------------
// fcb_back: execution stage of the blit unit
// Owns both stores, clears them after reset, runs byte accesses, and walks a
// clipped blit one pixel per cycle through a read / modify-write pipeline.
// ----------------------------------------------------------------------------
module fcb_back #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32,
    parameter int SPRITE_HEIGHT = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fcb_pkg::cmd_t         q_cmd,
    input  logic                  q_valid,
    output fcb_pkg::back_status_t status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_read_byte,
    output logic                  m_is_read
);

    localparam int FRAME_BYTES  = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
    localparam int SPRITE_BYTES = fcb_pkg::SPRITE_ROW * ((SPRITE_HEIGHT + 7) / 8);
    localparam int FADDR_W      = $clog2(FRAME_BYTES);
    localparam int SADDR_W      = $clog2(SPRITE_BYTES);
    localparam int CLR_N        = (FRAME_BYTES > SPRITE_BYTES) ? FRAME_BYTES : SPRITE_BYTES;
    localparam int CLR_W        = $clog2(CLR_N);
    localparam int WW           = fcb_pkg::WIDE_W;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_RUN   = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [CLR_W-1:0]   clr_idx_reg;
    fcb_pkg::cmd_t      cmd_reg;
    logic [6:0]         col_reg, row_reg;

    logic               pb_valid_reg, pb_src_ok_reg;
    logic [FADDR_W-1:0] pb_faddr_reg;
    logic [2:0]         pb_fbit_reg, pb_sbit_reg;
    logic               lw_valid_reg;
    logic [FADDR_W-1:0] lw_addr_reg;
    logic [7:0]         lw_data_reg;

    logic [7:0]         res_byte_reg;
    logic               res_is_read_reg;
    logic               m_valid_reg, m_is_read_reg;
    logic [7:0]         m_read_byte_reg;

    logic               idle_pop, res_free, clr_last, run_last;
    logic [9:0]         tx_full, ty_full;
    logic [7:0]         sxc, syr;
    logic               src_ok;
    logic [WW-1:0]      faddr_wide, saddr_wide;
    logic [FADDR_W-1:0] faddr_a, head_faddr;
    logic [SADDR_W-1:0] saddr_a;
    logic [7:0]         fbyte, mask, pb_new_byte;
    logic               pix;

    logic               f_we, spr_we;
    logic [FADDR_W-1:0] f_waddr, f_raddr;
    logic [7:0]         f_wdata, f_rdata, spr_wdata, spr_rdata;
    logic [SADDR_W-1:0] spr_waddr;

    assign idle_pop = (state_reg == ST_IDLE) && q_valid;
    assign res_free = !m_valid_reg || m_ready;
    assign clr_last = (clr_idx_reg == CLR_W'(CLR_N - 1));
    assign run_last = (col_reg == cmd_reg.col_last) && (row_reg == cmd_reg.row_last);

    assign status.clearing = (state_reg == ST_CLEAR);
    assign status.pop      = idle_pop;

    // Pixel addresses for the read stage.
    always_comb begin
        tx_full    = {{2{cmd_reg.dest_x[7]}}, cmd_reg.dest_x} + {3'b0, col_reg};
        ty_full    = {{2{cmd_reg.dest_y[7]}}, cmd_reg.dest_y} + {3'b0, row_reg};
        faddr_wide = WW'(tx_full[7:0]) + WW'(ty_full[6:3]) * WW'(SCREEN_WIDTH);
        faddr_a    = faddr_wide[FADDR_W-1:0];
        sxc        = {2'b0, cmd_reg.src_x} + {1'b0, col_reg};
        syr        = {2'b0, cmd_reg.src_y} + {1'b0, row_reg};
        src_ok     = (sxc < 8'(fcb_pkg::SPRITE_ROW)) && ({1'b0, syr} < 9'(SPRITE_HEIGHT));
        saddr_wide = WW'(sxc[5:0]) + WW'(syr[7:3]) * WW'(fcb_pkg::SPRITE_ROW);
        saddr_a    = saddr_wide[SADDR_W-1:0];
        head_faddr = FADDR_W'(q_cmd.address);
    end

    // Modify stage. The previous pixel's write may not yet be visible in the
    // read data when both hit the same byte, so it is forwarded.
    always_comb begin
        fbyte       = (lw_valid_reg && (lw_addr_reg == pb_faddr_reg)) ? lw_data_reg : f_rdata;
        mask        = 8'b1 << pb_fbit_reg;
        pix         = pb_src_ok_reg && spr_rdata[pb_sbit_reg];
        pb_new_byte = pix ? (fbyte | mask) : (fbyte & ~mask);
    end

    always_comb begin
        f_we      = 1'b0;
        f_waddr   = pb_faddr_reg;
        f_wdata   = pb_new_byte;
        spr_we    = 1'b0;
        spr_waddr = SADDR_W'(q_cmd.address);
        spr_wdata = q_cmd.data;
        if (state_reg == ST_CLEAR) begin
            f_we      = (WW'(clr_idx_reg) < WW'(FRAME_BYTES));
            f_waddr   = FADDR_W'(clr_idx_reg);
            f_wdata   = '0;
            spr_we    = (WW'(clr_idx_reg) < WW'(SPRITE_BYTES));
            spr_waddr = SADDR_W'(clr_idx_reg);
            spr_wdata = '0;
        end else if (pb_valid_reg) begin
            f_we = 1'b1;
        end else if (idle_pop && q_cmd.addr_ok) begin
            if (q_cmd.action == fcb_pkg::ACT_WR_FRAME) begin
                f_we    = 1'b1;
                f_waddr = head_faddr;
                f_wdata = q_cmd.data;
            end
            if (q_cmd.action == fcb_pkg::ACT_WR_SPRITE) begin
                spr_we = 1'b1;
            end
        end
        f_raddr = (state_reg == ST_IDLE) ? head_faddr : faddr_a;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    unique case (q_cmd.action)
                        fcb_pkg::ACT_RD_FRAME: state_next = ST_READ;
                        fcb_pkg::ACT_BLIT:     state_next = q_cmd.empty ? ST_DONE : ST_RUN;
                        default:               state_next = ST_DONE;
                    endcase
                end
            end
            ST_READ:  state_next = ST_DONE;
            ST_RUN: begin
                if (run_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE: begin
                if (res_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_idx_reg  <= '0;
            pb_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pb_valid_reg <= (state_reg == ST_RUN);
            lw_valid_reg <= pb_valid_reg;
            if (state_reg == ST_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if ((state_reg == ST_DONE) && res_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pb_faddr_reg  <= faddr_a;
        pb_fbit_reg   <= ty_full[2:0];
        pb_sbit_reg   <= syr[2:0];
        pb_src_ok_reg <= src_ok;
        lw_addr_reg   <= pb_faddr_reg;
        lw_data_reg   <= pb_new_byte;
        if (idle_pop) begin
            cmd_reg         <= q_cmd;
            col_reg         <= q_cmd.col_first;
            row_reg         <= q_cmd.row_first;
            res_byte_reg    <= '0;
            res_is_read_reg <= 1'b0;
        end
        if (state_reg == ST_RUN) begin
            if (col_reg == cmd_reg.col_last) begin
                col_reg <= cmd_reg.col_first;
                row_reg <= row_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
        if (state_reg == ST_READ) begin
            res_byte_reg    <= cmd_reg.addr_ok ? f_rdata : 8'h00;
            res_is_read_reg <= 1'b1;
        end
        if ((state_reg == ST_DONE) && res_free) begin
            m_read_byte_reg <= res_byte_reg;
            m_is_read_reg   <= res_is_read_reg;
        end
    end

    fcb_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_ram (
        .aclk  (aclk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    fcb_ram #(.WIDTH(8), .DEPTH(SPRITE_BYTES)) u_sprite_ram (
        .aclk  (aclk),
        .we    (spr_we),
        .waddr (spr_waddr),
        .wdata (spr_wdata),
        .raddr (saddr_a),
        .rdata (spr_rdata)
    );

    assign m_valid     = m_valid_reg;
    assign m_read_byte = m_read_byte_reg;
    assign m_is_read   = m_is_read_reg;

    a_drain_has_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> pb_valid_reg)
        else $error("drain cycle without a pending pixel write");

    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pb_valid_reg)
        else $error("pixel pipeline still busy while idle");

    a_run_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (col_reg <= cmd_reg.col_last) &&
                                  (row_reg <= cmd_reg.row_last))
        else $error("blit walk left the clipped rectangle");

endmodule
